FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the Carmichael test unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cmt_pkg.sv
// Package of the Carmichael test unit: map size constant and shared width helper.
// Depends on nothing; used by cmt_modmul, the top level and the testbench.
package cmt_pkg;

    localparam int unsigned MAX_N_DEFAULT = 65536;
    localparam int unsigned NUM_W = 16;

    // Bits needed to address a map of the given depth.
    function automatic int unsigned addr_width(input int unsigned depth);
        int unsigned w;
        w = 1;
        while ((1 << w) < depth) begin
            w = w + 1;
        end
        return w;
    endfunction

endpackage

FILE: rtl/cmt_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
module cmt_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/cmt_modmul.sv
// Shared modular multiplier: product = a * b mod m, one quotient bit per cycle.
// Depends on cmt_pkg for the operand width and on assert_macros.svh.
`include "assert_macros.svh"
module cmt_modmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [cmt_pkg::NUM_W-1:0] a,
    input  logic [cmt_pkg::NUM_W-1:0] b,
    input  logic [cmt_pkg::NUM_W-1:0] m,
    output logic                      done,
    output logic [cmt_pkg::NUM_W-1:0] product
);

    localparam int unsigned W  = cmt_pkg::NUM_W;
    localparam int unsigned PW = 2 * W;
    localparam int unsigned CW = $clog2(PW + 1);

    typedef enum logic [1:0] {MM_IDLE, MM_MUL, MM_RED} mm_state_t;

    mm_state_t       state_reg;
    logic [PW-1:0]   rem_reg;
    logic [W-1:0]    mod_reg;
    logic [CW-1:0]   cnt_reg;
    logic            done_reg;

    logic [PW:0]     trial;
    logic [PW-1:0]   shifted_mod;

    // Restoring reduction: subtract m shifted by the current bit position.
    always_comb
    begin
        shifted_mod = {{W{1'b0}}, mod_reg} << cnt_reg[CW-2:0];
        trial = {1'b0, rem_reg} - {1'b0, shifted_mod};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= MM_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            mod_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MM_IDLE:
                begin
                    if (go) begin
                        mod_reg   <= m;
                        rem_reg   <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
                        state_reg <= MM_MUL;
                    end
                end
                MM_MUL:
                begin
                    cnt_reg   <= CW'(W);
                    state_reg <= MM_RED;
                end
                MM_RED:
                begin
                    if (!trial[PW]) begin
                        rem_reg <= trial[PW-1:0];
                    end
                    if (cnt_reg == '0) begin
                        state_reg <= MM_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= MM_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign product = rem_reg[W-1:0];

    `ASSERT_NEXT(a_mm_go_leaves_idle, clk, rst_n, go && state_reg == MM_IDLE, state_reg == MM_MUL, "modmul did not start")
    `ASSERT_IMPL(a_mm_done_reduced, clk, rst_n, done_reg, rem_reg < PW'(mod_reg), "modmul result not reduced")

endmodule

FILE: rtl/carmichael_number_test_unit.sv
// Top level of the Carmichael number test unit: sieve, base walk and power sequencer.
// Depends on cmt_pkg, cmt_ram, cmt_modmul and assert_macros.svh.
//
// The unit takes one number n on a start pulse while busy is low and answers
// with is_carmichael, marked by done for exactly one cycle; the receiver cannot
// stall that transfer, so it must sample the result when done is high. After
// reset the unit clears and then sieves a prime map of MAX_N entries through
// its single map port, and holds busy high for that whole pass. A test of n
// walks the bases a from 2 up to n - 1, one map read per base, and stops at
// the first prime base with a^n mod n other than a; for each prime base it
// computes a^n mod n by square and multiply on one shared modular multiplier,
// so one base costs up to about 32 products. Primes, numbers below three and
// numbers at or beyond MAX_N answer without the base walk; for a composite n
// the multiplier sets the test time.
`include "assert_macros.svh"
module carmichael_number_test_unit #(
    parameter int unsigned MAX_N = cmt_pkg::MAX_N_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cmt_pkg::NUM_W-1:0] number,
    output logic                      busy,
    output logic                      done,
    output logic                      is_carmichael
);

    localparam int unsigned W  = cmt_pkg::NUM_W;
    localparam int unsigned AW = cmt_pkg::addr_width(MAX_N);
    localparam int unsigned XW = AW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_SV_RD, S_SV_WAIT, S_SV_CHK, S_SV_MARK,
        S_IDLE, S_N_WAIT, S_N_CHK, S_A_RD, S_A_WAIT, S_A_CHK,
        S_MUL_GO, S_MUL_WAIT, S_DONE
    } state_t;

    state_t          state_reg;
    logic [XW-1:0]   i_reg;
    logic [XW-1:0]   j_reg;
    logic [W-1:0]    n_reg;
    logic [W-1:0]    a_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    sq_reg;
    logic [W-1:0]    exp_reg;
    logic            sq_phase_reg;
    logic            result_reg;
    logic            done_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic            ram_wdata;
    logic            ram_rdata;

    logic            mm_go;
    logic [W-1:0]    mm_a;
    logic [W-1:0]    mm_b;
    logic            mm_done;
    logic [W-1:0]    mm_p;

    logic [2*XW-1:0] i_sq;
    logic [XW:0]     j_step;

    assign i_sq   = i_reg * i_reg;
    assign j_step = {1'b0, j_reg} + {1'b0, i_reg};

    // Map port: clear and mark in the sieve, otherwise read entry i, n or the base.
    // The address is held through the wait cycle so that the registered read
    // data still belongs to n or the base when it is checked.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = i_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (i_reg >= XW'(2));
            end
            S_SV_MARK:
            begin
                ram_we   = 1'b1;
                ram_addr = j_reg[AW-1:0];
            end
            S_IDLE:    ram_addr = AW'(number);
            S_N_WAIT:  ram_addr = AW'(n_reg);
            S_A_RD:    ram_addr = AW'(a_reg);
            S_A_WAIT:  ram_addr = AW'(a_reg);
            default:   ram_addr = i_reg[AW-1:0];
        endcase
    end

    cmt_ram #(.WIDTH(1), .DEPTH(MAX_N), .AW(AW)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The multiplier starts only when the sequencer really moves on to wait
    // for a product, never on a skipped multiply or at the end of a base.
    assign mm_go = (state_reg == S_MUL_GO) && (exp_reg != '0)
                   && (sq_phase_reg || exp_reg[0]);
    assign mm_a  = sq_phase_reg ? sq_reg : acc_reg;
    assign mm_b  = sq_reg;

    cmt_modmul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (mm_go),
        .a       (mm_a),
        .b       (mm_b),
        .m       (n_reg),
        .done    (mm_done),
        .product (mm_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_CLEAR;
            i_reg        <= '0;
            j_reg        <= '0;
            done_reg     <= 1'b0;
            result_reg   <= 1'b0;
            n_reg        <= '0;
            a_reg        <= '0;
            acc_reg      <= '0;
            sq_reg       <= '0;
            exp_reg      <= '0;
            sq_phase_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                // Sweep the map to all-prime, entries 0 and 1 excepted.
                S_CLEAR:
                begin
                    if (i_reg == XW'(MAX_N - 1)) begin
                        i_reg     <= XW'(2);
                        state_reg <= S_SV_RD;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_SV_RD:
                begin
                    if (i_sq >= (2*XW)'(MAX_N)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_SV_WAIT;
                    end
                end
                S_SV_WAIT: state_reg <= S_SV_CHK;
                S_SV_CHK:
                begin
                    if (ram_rdata) begin
                        j_reg     <= i_sq[XW-1:0];
                        state_reg <= S_SV_MARK;
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SV_RD;
                    end
                end
                S_SV_MARK:
                begin
                    if (j_step >= (XW+1)'(MAX_N)) begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_SV_RD;
                    end else begin
                        j_reg <= j_step[XW-1:0];
                    end
                end
                S_IDLE:
                begin
                    if (start) begin
                        n_reg     <= number;
                        state_reg <= S_N_WAIT;
                    end
                end
                S_N_WAIT: state_reg <= S_N_CHK;
                S_N_CHK:
                begin
                    if (n_reg < W'(3) || 32'(n_reg) >= 32'(MAX_N) || ram_rdata) begin
                        result_reg <= 1'b0;
                        state_reg  <= S_DONE;
                    end else begin
                        a_reg     <= W'(2);
                        state_reg <= S_A_RD;
                    end
                end
                S_A_RD:
                begin
                    if (a_reg >= n_reg) begin
                        result_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end else begin
                        state_reg <= S_A_WAIT;
                    end
                end
                S_A_WAIT: state_reg <= S_A_CHK;
                S_A_CHK:
                begin
                    if (ram_rdata) begin
                        acc_reg      <= W'(1);
                        sq_reg       <= a_reg;
                        exp_reg      <= n_reg;
                        sq_phase_reg <= 1'b0;
                        state_reg    <= S_MUL_GO;
                    end else begin
                        a_reg     <= a_reg + 1'b1;
                        state_reg <= S_A_RD;
                    end
                end
                // Multiply on a set low exponent bit, then square; at the end compare.
                S_MUL_GO:
                begin
                    if (exp_reg == '0) begin
                        if (acc_reg != a_reg) begin
                            result_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end else begin
                            a_reg     <= a_reg + 1'b1;
                            state_reg <= S_A_RD;
                        end
                    end else if (!sq_phase_reg && !exp_reg[0]) begin
                        sq_phase_reg <= 1'b1;
                    end else begin
                        state_reg <= S_MUL_WAIT;
                    end
                end
                S_MUL_WAIT:
                begin
                    if (mm_done) begin
                        if (sq_phase_reg) begin
                            sq_reg       <= mm_p;
                            exp_reg      <= exp_reg >> 1;
                            sq_phase_reg <= 1'b0;
                        end else begin
                            acc_reg      <= mm_p;
                            sq_phase_reg <= 1'b1;
                        end
                        state_reg <= S_MUL_GO;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign is_carmichael = result_reg;

    `ASSERT_NEXT(a_done_after_done_state, clk, rst_n, state_reg == S_DONE, done_reg && state_reg == S_IDLE, "result not delivered")
    `ASSERT_IMPL(a_done_not_busy, clk, rst_n, done_reg, !busy, "result while busy")
    `ASSERT_IMPL(a_base_below_n, clk, rst_n, state_reg == S_MUL_GO, a_reg < n_reg, "base out of range")

endmodule

FILE: tb/tb_top.sv
// Testbench of the Carmichael number test unit: directed and random numbers with a scoreboard.
// Depends on cmt_pkg and carmichael_number_test_unit; the predictor keeps its own prime sieve.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAP_DEPTH = cmt_pkg::MAX_N_DEFAULT;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam int unsigned CALM_ITEMS = 20;
    localparam longint unsigned CYCLE_LIMIT = 40_000_000;

    // The scoreboard predicts one verdict per accepted number and checks the
    // verdicts in the order in which the numbers were accepted.
    class carmichael_scoreboard;
        bit prime_bit [MAP_DEPTH];
        bit verdict_q [$];
        int mismatches;

        function void build_primes();
            int unsigned i;
            int unsigned j;
            foreach (prime_bit[k]) prime_bit[k] = 1'b1;
            prime_bit[0] = 1'b0;
            prime_bit[1] = 1'b0;
            for (i = 2; i * i < MAP_DEPTH; i++) begin
                if (prime_bit[i]) begin
                    for (j = i * i; j < MAP_DEPTH; j += i) prime_bit[j] = 1'b0;
                end
            end
        endfunction

        function longint unsigned power_mod(longint unsigned b, longint unsigned e,
                                            longint unsigned m);
            longint unsigned acc;
            longint unsigned sq;
            acc = 1 % m;
            sq = b % m;
            while (e != 0) begin
                if (e[0]) acc = (acc * sq) % m;
                sq = (sq * sq) % m;
                e = e >> 1;
            end
            return acc;
        endfunction

        function bit carmichael_verdict(int unsigned n);
            if (n < 3 || n >= MAP_DEPTH) return 1'b0;
            if (prime_bit[n]) return 1'b0;
            for (int unsigned a = 2; a < n; a++) begin
                if (prime_bit[a] && power_mod(a, n, n) != a) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_number(logic [cmt_pkg::NUM_W-1:0] n);
            verdict_q.push_back(carmichael_verdict(n));
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_verdict(logic got);
            bit want;
            if (verdict_q.size() == 0) begin
                report($sformatf("verdict %0b with no number outstanding", got));
            end
            else begin
                want = verdict_q.pop_front();
                if (got !== want)
                    report($sformatf("is_carmichael %0b, expected %0b", got, want));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic [cmt_pkg::NUM_W-1:0] number;
    logic busy;
    logic done;
    logic is_carmichael;

    carmichael_scoreboard sb;
    longint unsigned cycle_count;

    carmichael_number_test_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .number(number),
        .busy(busy),
        .done(done),
        .is_carmichael(is_carmichael)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Outputs are read right after the edge, before the block's own updates
    // land, so each read sees the values that the edge sampled.
    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_verdict(is_carmichael);
    end

    // The watchdog covers the sieve pass after reset, during which busy is high,
    // plus the slowest composite tests.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Presents one number and holds start until the transfer happens, that is
    // until an edge at which start is high and busy is low. An optional burst
    // of idle cycles comes first.
    task send_number(logic [cmt_pkg::NUM_W-1:0] n, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        number <= n;
        do @(posedge clk); while (busy);
        sb.note_number(n);
    endtask

    function int unsigned pick_gap(bit calm);
        if (calm || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(1, 15);
    endfunction

    // Random numbers are mostly drawn over the whole field, with a share of
    // small values, known Carmichael numbers and base-2 pseudoprimes mixed in.
    // Only the small Carmichael numbers are used: a Carmichael n makes the
    // block test every prime base below n, which is costly for large n.
    function logic [cmt_pkg::NUM_W-1:0] pick_number();
        int unsigned sel;
        sel = $urandom_range(0, 29);
        if (sel == 0) return 16'd561;
        if (sel == 1) return ($urandom_range(0, 1) != 0) ? 16'd1105 : 16'd341;
        if (sel < 10) return 16'($urandom_range(0, 700));
        return 16'($urandom);
    endfunction

    initial
    begin
        logic [cmt_pkg::NUM_W-1:0] directed [$];
        start = 1'b0;
        number = '0;
        rst_n = 1'b0;
        cycle_count = 0;
        sb = new();
        sb.build_primes();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Small numbers below three, the first odd prime and composite, the top
        // of the field, a large prime, a base-2 pseudoprime, squares of primes,
        // the smallest Carmichael numbers and further composites beside them.
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd561, 16'd65535,
                     16'd65534, 16'd65521, 16'd341, 16'd1105, 16'd1729, 16'd25,
                     16'd32768, 16'd255, 16'd21845, 16'd43690, 16'd560, 16'd562};
        foreach (directed[i]) send_number(directed[i], pick_gap(1'b0));

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
            send_number(pick_number(), pick_gap(i >= RANDOM_ITEMS - CALM_ITEMS));
        start <= 1'b0;

        while (sb.verdict_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
